// ----- hw/rtl/rbfl_pkg.sv -----
package rbfl_pkg;

	localparam int unsigned MAX_BUFFERS_DEF = 1024;
	localparam int unsigned COUNT_BITS_DEF  = 8;
	localparam int unsigned POOL_SIZE_RESET = 1024;
	localparam int unsigned QUEUE_DEPTH     = 2;

	typedef enum logic [1:0] {
		CMD_GET     = 2'd0,
		CMD_SHARE   = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_FULL     = 3'd2,
		ST_RANGE    = 3'd3,
		ST_OVERFLOW = 3'd4,
		ST_NOT_HELD = 3'd5
	} status_t;

	// work classes decided by the front end
	typedef enum logic [2:0] {
		OP_GET,
		OP_SHARE,
		OP_RELEASE,
		OP_RANGE,
		OP_NOP
	} op_kind_t;

	typedef enum logic [1:0] {
		ENG_CLEAR,
		ENG_FETCH,
		ENG_EXEC
	} eng_state_t;

endpackage

// ----- hw/rtl/rbfl_fifo.sv -----
module rbfl_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = rbfl_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	import rbfl_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/rbfl_front.sv -----
module rbfl_front #(
	parameter int unsigned IDX_W  = 10,
	parameter int unsigned SIZE_W = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [1:0]            command,
	input  logic [IDX_W-1:0]      packet_index,
	input  logic [SIZE_W-1:0]     pool_size,
	input  logic                  hold,
	output logic                  op_valid,
	input  logic                  op_pop,
	output rbfl_pkg::op_kind_t    op_kind,
	output logic [IDX_W-1:0]      op_index
);
	import rbfl_pkg::*;

	localparam int unsigned KIND_W = $bits(op_kind_t);
	localparam int unsigned OP_W   = KIND_W + IDX_W;

	op_kind_t        kind_in;
	logic            in_range;
	logic            q_full, q_empty;
	logic [OP_W-1:0] q_dout;

	assign in_range = ({1'b0, packet_index} < pool_size);

	always_comb begin
		unique case (cmd_t'(command))
			CMD_GET:     kind_in = OP_GET;
			CMD_SHARE:   kind_in = in_range ? OP_SHARE : OP_RANGE;
			CMD_RELEASE: kind_in = in_range ? OP_RELEASE : OP_RANGE;
			CMD_NOP:     kind_in = OP_NOP;
			default:     kind_in = OP_NOP;
		endcase
	end

	// no transfer while the engine is sweeping the memories
	assign full = q_full || hold;

	rbfl_fifo #(
		.WIDTH (OP_W),
		.DEPTH (QUEUE_DEPTH)
	) u_op_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && !full),
		.din   ({kind_in, packet_index}),
		.full  (q_full),
		.pop   (op_pop),
		.dout  (q_dout),
		.empty (q_empty)
	);

	assign op_valid = !q_empty;
	assign op_kind  = op_kind_t'(q_dout[OP_W-1 -: KIND_W]);
	assign op_index = q_dout[IDX_W-1:0];

endmodule

// ----- hw/rtl/rbfl_engine.sv -----
module rbfl_engine #(
	parameter int unsigned MAX_BUFFERS = 1024,
	parameter int unsigned COUNT_BITS  = 8,
	parameter int unsigned IDX_W       = 10,
	parameter int unsigned SIZE_W      = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [SIZE_W-1:0]     cfg_data,
	output logic [SIZE_W-1:0]     pool_size,
	output logic                  clearing,
	input  logic                  op_valid,
	output logic                  op_pop,
	input  rbfl_pkg::op_kind_t    op_kind,
	input  logic [IDX_W-1:0]      op_index,
	output logic                  res_push,
	input  logic                  res_full,
	output logic [IDX_W-1:0]      res_granted,
	output logic [2:0]            res_status,
	output logic                  res_freed,
	output logic [COUNT_BITS-1:0] res_ref_count,
	output logic [SIZE_W-1:0]     res_free_count
);
	import rbfl_pkg::*;

	localparam logic [SIZE_W-1:0] MAX_SIZE   = SIZE_W'(MAX_BUFFERS);
	localparam logic [SIZE_W-1:0] RESET_SIZE =
		SIZE_W'((POOL_SIZE_RESET < MAX_BUFFERS) ? POOL_SIZE_RESET : MAX_BUFFERS);
	localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

	logic [IDX_W-1:0]      ring_mem [MAX_BUFFERS];
	logic [COUNT_BITS-1:0] rc_mem   [MAX_BUFFERS];

	eng_state_t            state_q, state_nx;
	logic [SIZE_W-1:0]     pool_q, free_q, free_nx, cfg_size;
	logic [IDX_W-1:0]      wp_q, wp_nx, sweep_q;
	logic                  sweep_last;

	op_kind_t              op_kind_s1;
	logic [IDX_W-1:0]      op_index_s1;
	logic [IDX_W-1:0]      ring_rd_q;
	logic [COUNT_BITS-1:0] rc_rd_q;

	logic                  fetch, exec_fire;
	logic [SIZE_W-1:0]     wp_ext, pos_full;
	logic [IDX_W-1:0]      get_pos;

	logic                  ring_we, rc_we;
	logic [IDX_W-1:0]      rc_wa;
	logic [COUNT_BITS-1:0] rc_wd, rc_dec;
	logic                  mem_ring_we, mem_rc_we;
	logic [IDX_W-1:0]      mem_ring_wa, mem_ring_wd, mem_rc_wa;
	logic [COUNT_BITS-1:0] mem_rc_wd;

	assign cfg_size = (cfg_data == '0) ? SIZE_W'(1) :
	                  (cfg_data > MAX_SIZE) ? MAX_SIZE : cfg_data;
	assign pool_size  = pool_q;
	assign sweep_last = ({1'b0, sweep_q} == pool_q - SIZE_W'(1));

	// oldest free entry sits free_q places behind the write position
	assign wp_ext   = {1'b0, wp_q};
	assign pos_full = (wp_ext >= free_q) ? wp_ext - free_q : pool_q - free_q + wp_ext;
	assign get_pos  = pos_full[IDX_W-1:0];

	// next state
	always_comb begin
		state_nx = state_q;
		if (cfg_we) begin
			state_nx = ENG_CLEAR;
		end else begin
			unique case (state_q)
				ENG_CLEAR: if (sweep_last) state_nx = ENG_FETCH;
				ENG_FETCH: if (op_valid) state_nx = ENG_EXEC;
				ENG_EXEC:  if (!res_full) state_nx = ENG_FETCH;
				default:   state_nx = ENG_CLEAR;
			endcase
		end
	end

	// fsm outputs
	always_comb begin
		clearing  = 1'b0;
		fetch     = 1'b0;
		exec_fire = 1'b0;
		unique case (state_q)
			ENG_CLEAR: clearing = 1'b1;
			ENG_FETCH: fetch = op_valid;
			ENG_EXEC:  exec_fire = !res_full;
			default:   clearing = 1'b1;
		endcase
	end

	assign op_pop   = fetch;
	assign res_push = exec_fire;

	// command execution on the fetched memory words
	always_comb begin
		res_granted   = '0;
		res_status    = ST_OK;
		res_freed     = 1'b0;
		res_ref_count = '0;
		wp_nx         = wp_q;
		free_nx       = free_q;
		ring_we       = 1'b0;
		rc_we         = 1'b0;
		rc_wa         = op_index_s1;
		rc_wd         = '0;
		rc_dec        = rc_rd_q - COUNT_BITS'(1);
		unique case (op_kind_s1)
			OP_GET: begin
				if (free_q == '0) begin
					res_status = ST_EMPTY;
				end else begin
					res_granted   = ring_rd_q;
					res_ref_count = COUNT_BITS'(1);
					free_nx       = free_q - SIZE_W'(1);
					rc_we         = 1'b1;
					rc_wa         = ring_rd_q;
					rc_wd         = COUNT_BITS'(1);
				end
			end
			OP_SHARE: begin
				if (rc_rd_q == '0) begin
					res_status = ST_NOT_HELD;
				end else if (rc_rd_q == CMAX) begin
					res_status    = ST_OVERFLOW;
					res_ref_count = CMAX;
				end else begin
					res_ref_count = rc_rd_q + COUNT_BITS'(1);
					rc_we         = 1'b1;
					rc_wd         = rc_rd_q + COUNT_BITS'(1);
				end
			end
			OP_RELEASE: begin
				if (rc_rd_q == '0) begin
					res_status = ST_NOT_HELD;
				end else begin
					res_ref_count = rc_dec;
					rc_we         = 1'b1;
					rc_wd         = rc_dec;
					if (rc_dec == '0) begin
						if (free_q >= pool_q) begin
							res_status = ST_FULL;
						end else begin
							ring_we   = 1'b1;
							res_freed = 1'b1;
							free_nx   = free_q + SIZE_W'(1);
							wp_nx     = (wp_ext + SIZE_W'(1) == pool_q) ? '0 : wp_q + IDX_W'(1);
						end
					end
				end
			end
			OP_RANGE: res_status = ST_RANGE;
			OP_NOP:   res_status = ST_OK;
			default:  res_status = ST_OK;
		endcase
		res_free_count = free_nx;
	end

	// one write port per memory: sweep or command
	always_comb begin
		if (clearing) begin
			mem_ring_we = 1'b1;
			mem_ring_wa = sweep_q;
			mem_ring_wd = sweep_q;
			mem_rc_we   = 1'b1;
			mem_rc_wa   = sweep_q;
			mem_rc_wd   = '0;
		end else begin
			mem_ring_we = ring_we && exec_fire;
			mem_ring_wa = wp_q;
			mem_ring_wd = op_index_s1;
			mem_rc_we   = rc_we && exec_fire;
			mem_rc_wa   = rc_wa;
			mem_rc_wd   = rc_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_ring_we) begin
			ring_mem[mem_ring_wa] <= mem_ring_wd;
		end
		if (fetch) begin
			ring_rd_q <= ring_mem[get_pos];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_rc_we) begin
			rc_mem[mem_rc_wa] <= mem_rc_wd;
		end
		if (fetch) begin
			rc_rd_q <= rc_mem[op_index];
		end
	end

	always_ff @(posedge clk) begin
		if (fetch) begin
			op_kind_s1  <= op_kind;
			op_index_s1 <= op_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ENG_CLEAR;
			pool_q  <= RESET_SIZE;
			free_q  <= RESET_SIZE;
			wp_q    <= '0;
			sweep_q <= '0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				pool_q  <= cfg_size;
				free_q  <= cfg_size;
				wp_q    <= '0;
				sweep_q <= '0;
			end else begin
				if (clearing) begin
					sweep_q <= sweep_q + IDX_W'(1);
				end
				if (exec_fire) begin
					wp_q   <= wp_nx;
					free_q <= free_nx;
				end
			end
		end
	end

endmodule

// ----- hw/rtl/refcounted_buffer_free_list_top.sv -----
// Reference-counted buffer free list. get hands out the oldest free buffer index with a count
// of one, share adds a reference, release drops one and returns the index to the free ring
// when the count reaches zero; every command gives exactly one result on the output queue.
// Commands enter a two-entry queue and are executed by an engine that reads the count and ring
// memories in its fetch state and writes them back in its exec state, taking a new command
// only after the result of the last one is pushed; exec waits while the result queue is full.
// After reset and after every write of pool_size the engine sweeps the ring and count memories,
// one entry a cycle, over pool_size entries; full stays high during that pass. Write pool_size
// only while no command or result is in flight.
module refcounted_buffer_free_list_top #(
	parameter int unsigned MAX_BUFFERS = rbfl_pkg::MAX_BUFFERS_DEF,
	parameter int unsigned COUNT_BITS  = rbfl_pkg::COUNT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [$clog2(MAX_BUFFERS):0]       cfg_data,
	input  logic                               push,
	output logic                               full,
	input  logic [1:0]                         command,
	input  logic [$clog2(MAX_BUFFERS)-1:0]     packet_index,
	output logic                               empty,
	input  logic                               pop,
	output logic [$clog2(MAX_BUFFERS)-1:0]     granted_index,
	output logic [2:0]                         status,
	output logic                               freed,
	output logic [COUNT_BITS-1:0]              ref_count,
	output logic [$clog2(MAX_BUFFERS):0]       free_count
);
	import rbfl_pkg::*;

	localparam int unsigned IDX_W  = $clog2(MAX_BUFFERS);
	localparam int unsigned SIZE_W = IDX_W + 1;
	localparam int unsigned RES_W  = IDX_W + 3 + 1 + COUNT_BITS + SIZE_W;

	logic [SIZE_W-1:0]     pool_size;
	logic                  clearing;
	logic                  op_valid, op_pop;
	op_kind_t              op_kind;
	logic [IDX_W-1:0]      op_index;
	logic                  res_push, res_full;
	logic [IDX_W-1:0]      res_granted;
	logic [2:0]            res_status;
	logic                  res_freed;
	logic [COUNT_BITS-1:0] res_ref_count;
	logic [SIZE_W-1:0]     res_free_count;
	logic [RES_W-1:0]      res_dout;

	rbfl_front #(
		.IDX_W (IDX_W),
		.SIZE_W(SIZE_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.command     (command),
		.packet_index(packet_index),
		.pool_size   (pool_size),
		.hold        (clearing),
		.op_valid    (op_valid),
		.op_pop      (op_pop),
		.op_kind     (op_kind),
		.op_index    (op_index)
	);

	rbfl_engine #(
		.MAX_BUFFERS(MAX_BUFFERS),
		.COUNT_BITS (COUNT_BITS),
		.IDX_W      (IDX_W),
		.SIZE_W     (SIZE_W)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.pool_size     (pool_size),
		.clearing      (clearing),
		.op_valid      (op_valid),
		.op_pop        (op_pop),
		.op_kind       (op_kind),
		.op_index      (op_index),
		.res_push      (res_push),
		.res_full      (res_full),
		.res_granted   (res_granted),
		.res_status    (res_status),
		.res_freed     (res_freed),
		.res_ref_count (res_ref_count),
		.res_free_count(res_free_count)
	);

	rbfl_fifo #(
		.WIDTH(RES_W),
		.DEPTH(QUEUE_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   ({res_granted, res_status, res_freed, res_ref_count, res_free_count}),
		.full  (res_full),
		.pop   (pop),
		.dout  (res_dout),
		.empty (empty)
	);

	assign {granted_index, status, freed, ref_count, free_count} = res_dout;

endmodule

// ----- hw/rtl/rbfl_checker.sv -----
module rbfl_checker #(
	parameter int unsigned MAX_BUFFERS = rbfl_pkg::MAX_BUFFERS_DEF,
	parameter int unsigned COUNT_BITS  = rbfl_pkg::COUNT_BITS_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_we,
	input logic [$clog2(MAX_BUFFERS):0]   cfg_data,
	input logic                           push,
	input logic                           full,
	input logic [1:0]                     command,
	input logic [$clog2(MAX_BUFFERS)-1:0] packet_index,
	input logic                           empty,
	input logic                           pop,
	input logic [$clog2(MAX_BUFFERS)-1:0] granted_index,
	input logic [2:0]                     status,
	input logic                           freed,
	input logic [COUNT_BITS-1:0]          ref_count,
	input logic [$clog2(MAX_BUFFERS):0]   free_count
);
	import rbfl_pkg::*;

	// a waiting result holds until its transfer
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(granted_index) && $stable(status)
			&& $stable(freed) && $stable(ref_count) && $stable(free_count)))
		else $error("result changed while stalled");

	// reset leaves the block sweeping with nothing to deliver
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> (full && empty))
		else $error("block not idle in reset");

	// a pool size write starts the memory sweep
	a_cfg_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> full)
		else $error("input open right after pool size write");

	// a freeing release is successful, leaves the count at zero and a free buffer
	a_freed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && freed) |-> (status == ST_OK && ref_count == '0
			&& free_count != '0 && granted_index == '0))
		else $error("inconsistent freed result");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (free_count <= ($clog2(MAX_BUFFERS) + 1)'(MAX_BUFFERS)))
		else $error("free count above pool maximum");

endmodule

bind refcounted_buffer_free_list_top rbfl_checker #(
	.MAX_BUFFERS(MAX_BUFFERS),
	.COUNT_BITS (COUNT_BITS)
) u_rbfl_checker (.*);
